// File: rtl/erbp_pkg.sv
// Package for the retry backoff policy block.
// Holds widths, error-kind and class codes, register indexes and shared types.
// No dependencies.
package erbp_pkg;

    localparam int DELAY_BITS = 16;
    localparam int SCALED_W   = DELAY_BITS + 3;
    localparam int GROWTH_W   = 5;
    localparam int PROD_W     = SCALED_W + GROWTH_W;
    localparam int KIND_W     = 3;
    localparam int TRIES_W    = 8;
    localparam int CLASS_W    = 7;
    localparam int DELAY_MS_W = 19;
    localparam int CFG_IDX_W  = 3;
    localparam int LIMIT_W    = 8;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [KIND_W-1:0] KIND_EIO       = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ETIMEDOUT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ENOMEM    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ENODEV    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_EREMOTEIO = 3'd4;

    localparam int CLS_TRANSIENT  = 0;
    localparam int CLS_PERSISTENT = 1;
    localparam int CLS_HARDWARE   = 2;
    localparam int CLS_TIMEOUT    = 3;
    localparam int CLS_CRITICAL   = 4;
    localparam int CLS_MEMORY     = 5;
    localparam int CLS_DEVICE     = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_MS          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_CAP        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GROWTH_FACTOR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PERSISTENT_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_FAIL        = 3'd5;

    typedef struct packed {
        logic [LIMIT_W-1:0]    retry_limit;
        logic [DELAY_BITS-1:0] base_ms;
        logic [DELAY_BITS-1:0] delay_cap;
        logic [GROWTH_W-1:0]   growth_factor;
        logic [LIMIT_W-1:0]    persistent_limit;
        logic                  fast_fail;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        retry_limit:      8'd5,
        base_ms:          DELAY_BITS'(10),
        delay_cap:        DELAY_BITS'(5000),
        growth_factor:    5'd2,
        persistent_limit: 8'd3,
        fast_fail:        1'b1
    };

    typedef struct packed {
        logic [CLASS_W-1:0]  cls_bits;
        logic                do_retry;
        logic [TRIES_W-1:0]  tries;
        logic [SCALED_W-1:0] delay;
    } item_t;

endpackage

// File: rtl/erbp_front.sv
// Front end: accepts a word, classifies the error, decides on retry
// and scales the base delay by class. Depends on erbp_pkg.
module erbp_front (
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [erbp_pkg::KIND_W-1:0]  s_error_kind,
    input  logic [erbp_pkg::TRIES_W-1:0] s_retry_count,
    input  logic                         s_memory_pressure,
    input  erbp_pkg::cfg_t               cfg,
    input  logic                         q_full,
    output logic                         push,
    output erbp_pkg::item_t              push_item
);
    import erbp_pkg::*;

    logic [CLASS_W-1:0]  cls;
    logic                retry;
    logic [SCALED_W-1:0] base_ext;
    logic [SCALED_W-1:0] scaled;

    assign s_ready = !q_full;
    assign push    = s_valid && !q_full;

    always_comb begin
        cls = '0;
        unique case (s_error_kind)
            KIND_EIO: begin
                if (s_retry_count < 8'd2) begin
                    cls[CLS_TRANSIENT] = 1'b1;
                end else begin
                    cls[CLS_PERSISTENT] = 1'b1;
                    cls[CLS_HARDWARE]   = 1'b1;
                end
            end
            KIND_ETIMEDOUT: begin
                cls[CLS_TRANSIENT]  = 1'b1;
                cls[CLS_TIMEOUT]    = 1'b1;
                cls[CLS_PERSISTENT] = (s_retry_count > 8'd3);
            end
            KIND_ENOMEM: begin
                cls[CLS_CRITICAL] = 1'b1;
                cls[CLS_MEMORY]   = 1'b1;
            end
            KIND_ENODEV: begin
                cls[CLS_CRITICAL]   = 1'b1;
                cls[CLS_DEVICE]     = 1'b1;
                cls[CLS_PERSISTENT] = 1'b1;
            end
            KIND_EREMOTEIO: begin
                cls[CLS_TRANSIENT] = 1'b1;
                cls[CLS_HARDWARE]  = (s_retry_count > 8'd2);
            end
            default: begin
                if (s_retry_count == '0) begin
                    cls[CLS_TRANSIENT] = 1'b1;
                end else begin
                    cls[CLS_PERSISTENT] = 1'b1;
                end
            end
        endcase
    end

    always_comb begin
        priority if (cfg.fast_fail && cls[CLS_CRITICAL]) begin
            retry = 1'b0;
        end else if (cls[CLS_DEVICE]) begin
            retry = 1'b0;
        end else if (s_retry_count >= cfg.retry_limit) begin
            retry = 1'b0;
        end else if (cls[CLS_PERSISTENT] && s_retry_count >= cfg.persistent_limit) begin
            retry = 1'b0;
        end else if (cls[CLS_MEMORY]) begin
            retry = (s_retry_count == '0) && !s_memory_pressure;
        end else if (cls[CLS_TRANSIENT]) begin
            retry = 1'b1;
        end else begin
            retry = (s_retry_count < 8'd2);
        end
    end

    assign base_ext = SCALED_W'(cfg.base_ms);

    always_comb begin
        priority if (cls[CLS_TIMEOUT]) begin
            scaled = base_ext << 1;
        end else if (cls[CLS_MEMORY]) begin
            scaled = (s_retry_count == '0) ? SCALED_W'(1) : base_ext + (base_ext << 2);
        end else if (cls[CLS_HARDWARE]) begin
            scaled = base_ext + (base_ext << 1);
        end else begin
            scaled = base_ext;
        end
    end

    always_comb begin
        push_item.cls_bits = cls;
        push_item.do_retry = retry;
        push_item.tries    = s_retry_count;
        push_item.delay    = scaled;
    end

endmodule

// File: rtl/erbp_queue.sv
// Short FIFO of classified words between front and back ends.
// Depends on erbp_pkg.
module erbp_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  erbp_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            q_valid,
    output erbp_pkg::item_t q_item
);
    import erbp_pkg::*;

    item_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign full    = (cnt_reg == QCNT_W'(QDEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_item  = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= QCNT_W'(QDEPTH))
        else $error("queue count out of range");

    a_push_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        do_push |=> q_valid)
        else $error("queue empty after push");

endmodule

// File: rtl/erbp_back.sv
// Back end: iterative capped growth of the delay, one multiply per cycle,
// and the result output register. Depends on erbp_pkg.
module erbp_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  erbp_pkg::cfg_t                  cfg,
    input  logic                            q_valid,
    input  erbp_pkg::item_t                 q_item,
    output logic                            q_pop,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [erbp_pkg::CLASS_W-1:0]    m_error_class,
    output logic                            m_do_retry,
    output logic [erbp_pkg::DELAY_MS_W-1:0] m_delay_ms
);
    import erbp_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                  state_reg, state_next;
    logic [TRIES_W-1:0]    cnt_reg, cnt_next;
    logic [SCALED_W-1:0]   d_reg, d_next;
    logic [CLASS_W-1:0]    cls_reg, cls_next;
    logic                  retry_reg, retry_next;
    logic                  m_valid_reg, m_valid_next;
    logic [CLASS_W-1:0]    m_class_reg, m_class_next;
    logic                  m_retry_reg, m_retry_next;
    logic [DELAY_MS_W-1:0] m_delay_reg, m_delay_next;
    logic [PROD_W-1:0]     prod;
    logic                  over;
    logic                  out_free;

    assign prod     = PROD_W'(d_reg) * PROD_W'(cfg.growth_factor);
    assign over     = prod > PROD_W'(cfg.delay_cap);
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        d_next       = d_reg;
        cls_next     = cls_reg;
        retry_next   = retry_reg;
        m_valid_next = m_valid_reg;
        m_class_next = m_class_reg;
        m_retry_next = m_retry_reg;
        m_delay_next = m_delay_reg;
        q_pop        = 1'b0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    cnt_next   = q_item.tries;
                    d_next     = q_item.delay;
                    cls_next   = q_item.cls_bits;
                    retry_next = q_item.do_retry;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (cnt_reg == '0) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_class_next = cls_reg;
                        m_retry_next = retry_reg;
                        m_delay_next = DELAY_MS_W'(d_reg);
                        state_next   = ST_IDLE;
                    end
                end else if (over) begin
                    d_next   = SCALED_W'(cfg.delay_cap);
                    cnt_next = '0;
                end else begin
                    // factor 0/1 or zero delay: later steps change nothing
                    d_next = prod[SCALED_W-1:0];
                    if (cfg.growth_factor <= 5'd1 || prod == '0) begin
                        cnt_next = '0;
                    end else begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg     <= cnt_next;
        d_reg       <= d_next;
        cls_reg     <= cls_next;
        retry_reg   <= retry_next;
        m_class_reg <= m_class_next;
        m_retry_reg <= m_retry_next;
        m_delay_reg <= m_delay_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_error_class = m_class_reg;
    assign m_do_retry    = m_retry_reg;
    assign m_delay_ms    = m_delay_reg;

    a_out_from_run: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_RUN && $past(cnt_reg) == '0)
        else $error("result loaded outside a finished run");

    a_step_capped: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && cnt_reg != '0) |=>
        d_reg <= SCALED_W'($past(cfg.delay_cap)))
        else $error("growth step left delay above cap");

    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> state_reg == ST_RUN && cnt_reg == $past(q_item.tries))
        else $error("popped word not loaded into run");

endmodule

// File: rtl/io_error_retry_backoff_policy.sv
// Retry backoff policy, top level: config registers, front end, queue, back end.
// The back end pops a word, runs n growth steps, n <= min(retry_count, DELAY_BITS),
// then loads the result into the output register once that register is free.
// It takes no new word from the queue until the current result is loaded.
// Reset (aresetn, synchronous, low): queue and pipeline empty, registers to defaults.
// Depends on erbp_pkg, erbp_front, erbp_queue, erbp_back.
module io_error_retry_backoff_policy (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [erbp_pkg::KIND_W-1:0]       s_error_kind,
    input  logic [erbp_pkg::TRIES_W-1:0]      s_retry_count,
    input  logic                              s_memory_pressure,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [erbp_pkg::CLASS_W-1:0]      m_error_class,
    output logic                              m_do_retry,
    output logic [erbp_pkg::DELAY_MS_W-1:0]   m_delay_ms,
    input  logic                              cfg_we,
    input  logic [erbp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [erbp_pkg::DELAY_BITS-1:0]   cfg_data
);
    import erbp_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    logic  push, q_full, q_valid, q_pop;
    item_t push_item, q_item;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_RETRY_LIMIT:      cfg_next.retry_limit      = cfg_data[LIMIT_W-1:0];
                CFG_BASE_MS:          cfg_next.base_ms          = cfg_data;
                CFG_DELAY_CAP:        cfg_next.delay_cap        = cfg_data;
                CFG_GROWTH_FACTOR:    cfg_next.growth_factor    = cfg_data[GROWTH_W-1:0];
                CFG_PERSISTENT_LIMIT: cfg_next.persistent_limit = cfg_data[LIMIT_W-1:0];
                CFG_FAST_FAIL:        cfg_next.fast_fail        = cfg_data[0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    erbp_front u_front (
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_error_kind      (s_error_kind),
        .s_retry_count     (s_retry_count),
        .s_memory_pressure (s_memory_pressure),
        .cfg               (cfg_reg),
        .q_full            (q_full),
        .push              (push),
        .push_item         (push_item)
    );

    erbp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    erbp_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_error_class (m_error_class),
        .m_do_retry    (m_do_retry),
        .m_delay_ms    (m_delay_ms)
    );

endmodule
